FILE: src/mlts_pkg.sv
// Shared types, register indexes, reset values and helpers of the time-share scheduler.
package mlts_pkg;

    localparam int NS_W   = 62;
    localparam int LT_W   = 63;
    localparam int MULT_W = 16;
    localparam int ACC_W  = 126;
    localparam int NUM_THR = 5;

    localparam logic [LT_W-1:0] SAT63 = {LT_W{1'b1}};
    localparam logic [NS_W-1:0] SAT62 = {NS_W{1'b1}};

    localparam logic [MULT_W-1:0] MULT_ONE = 16'd256;

    typedef enum logic [1:0] {
        OP_CHARGE = 2'd0,
        OP_OFFER  = 2'd1,
        OP_SELECT = 2'd2,
        OP_RECORD = 2'd3
    } t_op;

    localparam logic [2:0] CFG_THR0 = 3'd0;
    localparam logic [2:0] CFG_THR1 = 3'd1;
    localparam logic [2:0] CFG_THR2 = 3'd2;
    localparam logic [2:0] CFG_THR3 = 3'd3;
    localparam logic [2:0] CFG_THR4 = 3'd4;
    localparam logic [2:0] CFG_MULT = 3'd5;
    localparam logic [2:0] CFG_CAP  = 3'd6;

    localparam logic [NS_W-1:0] THR0_RST = 62'd0;
    localparam logic [NS_W-1:0] THR1_RST = 62'd1000000000;
    localparam logic [NS_W-1:0] THR2_RST = 62'd10000000000;
    localparam logic [NS_W-1:0] THR3_RST = 62'd60000000000;
    localparam logic [NS_W-1:0] THR4_RST = 62'd300000000000;
    localparam logic [MULT_W-1:0] MULT_RST = 16'd512;
    localparam logic [NS_W-1:0] CAP_RST  = 62'd30000000000;

    typedef struct packed {
        logic [NUM_THR-1:0][NS_W-1:0] thr;
        logic [MULT_W-1:0]            mult;
        logic [NS_W-1:0]              cap;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_arith_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_arith_rsp;

    typedef struct packed {
        logic            level_found;
        logic [2:0]      chosen_level;
        logic [NS_W-1:0] new_priority;
        logic [2:0]      next_level;
    } t_result;

    // level account add, saturating at the top of the 63-bit range
    function automatic logic [LT_W-1:0] add63(input logic [LT_W-1:0] a,
                                              input logic [NS_W-1:0] b);
        logic [LT_W:0] s;
        s = {1'b0, a} + {2'b00, b};
        return s[LT_W] ? SAT63 : s[LT_W-1:0];
    endfunction

    // priority add, saturating at the top of the 62-bit range
    function automatic logic [NS_W-1:0] add62(input logic [NS_W-1:0] a,
                                              input logic [NS_W-1:0] b);
        logic [NS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[NS_W] ? SAT62 : s[NS_W-1:0];
    endfunction

endpackage

FILE: src/mlts_arith.sv
// Shared bit-serial multiply / restoring divide unit.
module mlts_arith import mlts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_arith_req        i_req,
    input  logic [LT_W-1:0]   i_a,      // multiplicand, or divisor in the low bits
    input  logic [LT_W-1:0]   i_b,      // multiplier, or dividend (scaled by 256 inside)
    output t_arith_rsp        o_rsp,
    output logic [ACC_W-1:0]  o_acc,    // product, or quotient in the low bits
    output logic [MULT_W-1:0] o_rem
);

    localparam int SH_W = LT_W + 8;
    localparam int CNT_W = $clog2(SH_W + 1);

    logic              r_busy;
    logic              r_done;
    logic              r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic [LT_W-1:0]   r_a;
    logic [SH_W-1:0]   r_sh;
    logic [ACC_W-1:0]  r_acc;
    logic [MULT_W:0]   r_rem;

    logic [MULT_W:0]   rem_sh;
    logic              ge;
    logic [MULT_W:0]   rem_nx;
    logic [ACC_W-1:0]  addend;
    logic [ACC_W-1:0]  acc_nx;

    always_comb begin
        rem_sh = {r_rem[MULT_W-1:0], r_sh[SH_W-1]};
        ge     = rem_sh >= {1'b0, r_a[MULT_W-1:0]};
        rem_nx = ge ? rem_sh - {1'b0, r_a[MULT_W-1:0]} : rem_sh;
        if (r_div) begin
            addend = {{(ACC_W-1){1'b0}}, ge};
        end else begin
            addend = r_sh[SH_W-1] ? {{(ACC_W-LT_W){1'b0}}, r_a} : '0;
        end
        acc_nx = {r_acc[ACC_W-2:0], 1'b0} + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_div  <= i_req.is_div;
                r_a    <= i_a;
                r_sh   <= {i_b, 8'd0};
                r_acc  <= '0;
                r_rem  <= '0;
                r_cnt  <= i_req.is_div ? CNT_W'(SH_W) : CNT_W'(LT_W);
            end else if (r_busy) begin
                r_acc <= acc_nx;
                r_sh  <= {r_sh[SH_W-2:0], 1'b0};
                if (r_div) begin
                    r_rem <= rem_nx;
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done};
    assign o_acc = r_acc;
    assign o_rem = r_rem[MULT_W-1:0];

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CNT_W'(1)) |=> r_done) else $error("missing done");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("busy with zero count");

endmodule

FILE: src/mlts_seq.sv
// Sequencer: level accounts, minimum priorities and the operation flows.
module mlts_seq import mlts_pkg::*; #(
    parameter int NUM_LEVELS = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic            i_start,
    input  t_op             i_op,
    input  logic [2:0]      i_level,
    input  logic [NS_W-1:0] i_prio,
    input  logic [NS_W-1:0] i_quanta,
    input  logic [NS_W-1:0] i_total,
    input  logic [4:0]      i_mask,
    output logic            o_ready,
    output logic            o_res_valid,
    output t_result         o_res,
    input  logic            i_out_free
);

    localparam int LW = $clog2(NUM_LEVELS);
    localparam logic [LW-1:0] LAST_LVL = LW'(NUM_LEVELS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_CH_DEC, S_CH_SAME, S_CH_WALK, S_CH_LAST, S_REC,
        S_TG_INIT, S_TG_LOAD, S_TG_UP, S_TG_UPW, S_TG_END,
        S_OF_DIV, S_OF_DIVW, S_OF_WR,
        S_SE_CHK, S_SE_M1W, S_SE_M2W, S_SE_ADV, S_SE_DIVW,
        S_FIN
    } t_state;

    t_state          r_state;
    t_op             r_op;
    logic [LW-1:0]   r_lv;
    logic [NS_W-1:0] r_prio;
    logic [NS_W-1:0] r_quanta;
    logic [NS_W-1:0] r_total;
    logic [4:0]      r_mask;
    logic [LW-1:0]   r_l;
    logic [LW-1:0]   r_k;
    logic [LW-1:0]   r_nl;
    logic [NS_W-1:0] r_contrib;
    logic [NS_W-1:0] r_task;
    logic [NS_W-1:0] r_thr_cur;
    logic [LT_W-1:0] r_y;
    logic [LT_W-1:0] r_d;
    logic [LT_W-1:0] r_best;
    logic [LT_W-1:0] r_t;
    logic [LT_W-1:0] r_bn;
    logic [LT_W-1:0] r_bd;
    logic            r_found;
    logic [LW-1:0]   r_chosen;
    logic [ACC_W-1:0] r_p1;
    t_result         r_res;
    t_arith_req      r_req;
    logic [LT_W-1:0] r_opa;
    logic [LT_W-1:0] r_opb;

    logic [LT_W-1:0] r_lt     [NUM_LEVELS];
    logic [NS_W-1:0] r_mp     [NUM_LEVELS];
    logic            r_mp_set [NUM_LEVELS];

    t_arith_rsp       arith_rsp;
    logic [ACC_W-1:0] arith_acc;
    logic [MULT_W-1:0] arith_rem;

    logic [MULT_W-1:0] eff_m;
    logic [LW-1:0]   lv_in;
    logic [LW-1:0]   nl;
    logic [LW-1:0]   l_inc;
    logic [LW-1:0]   k_inc;
    logic [LT_W-1:0] lt_rd;
    logic [NS_W-1:0] thr_nx;
    logic [NS_W-1:0] span;
    logic [NS_W-1:0] part;
    logic [NS_W-1:0] contrib_in;
    logic [LT_W-1:0] up_val;
    logic            rnd_up;
    logic [NS_W-1:0] mp_base;
    logic [LT_W-1:0] sel_n;
    logic [LT_W-1:0] sel_d;

    mlts_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .o_rsp   (arith_rsp),
        .o_acc   (arith_acc),
        .o_rem   (arith_rem)
    );

    always_comb begin
        eff_m = (i_cfg.mult < MULT_ONE) ? MULT_ONE : i_cfg.mult;
        lv_in = (i_level >= 3'(NUM_LEVELS)) ? LAST_LVL : LW'(i_level);
        // first level whose next threshold lies above the total run time
        nl = LAST_LVL;
        for (int l = NUM_LEVELS - 2; l >= 0; l--) begin
            if (r_total < i_cfg.thr[l + 1]) begin
                nl = LW'(l);
            end
        end
        l_inc      = r_l + 1'b1;
        k_inc      = r_k + 1'b1;
        lt_rd      = r_lt[r_l];
        thr_nx     = i_cfg.thr[l_inc];
        span       = (thr_nx >= r_thr_cur) ? thr_nx - r_thr_cur : '0;
        part       = (span < r_contrib) ? span : r_contrib;
        contrib_in = (r_quanta < i_cfg.cap) ? r_quanta : i_cfg.cap;
        up_val     = (|arith_acc[ACC_W-1:LT_W+8]) ? SAT63 : arith_acc[LT_W+7:8];
        rnd_up     = {arith_rem, 1'b0} >= {1'b0, eff_m};
        mp_base    = r_mp_set[r_l] ? r_mp[r_l] : r_total;
        sel_n      = (lt_rd != '0) ? r_t : '0;
        sel_d      = (lt_rd != '0) ? lt_rd : LT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= '0;
            r_found <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_lt[l]     <= '0;
                r_mp_set[l] <= 1'b0;
            end
        end else begin
            r_req <= '0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op     <= i_op;
                        r_lv     <= lv_in;
                        r_prio   <= i_prio;
                        r_quanta <= i_quanta;
                        r_total  <= i_total;
                        r_mask   <= i_mask;
                        r_res    <= '0;
                        r_l      <= lv_in;
                        unique case (i_op)
                            OP_CHARGE: r_state <= S_CH_DEC;
                            OP_RECORD: r_state <= S_REC;
                            OP_OFFER: begin
                                r_l     <= '0;
                                r_state <= i_mask[lv_in] ? S_FIN : S_TG_INIT;
                            end
                            default: begin
                                r_l     <= '0;
                                r_state <= S_TG_INIT;
                            end
                        endcase
                    end
                end
                S_CH_DEC: begin
                    r_nl      <= nl;
                    r_contrib <= contrib_in;
                    r_task    <= r_quanta;
                    r_thr_cur <= i_cfg.thr[r_lv];
                    if (nl == r_lv) begin
                        r_state <= S_CH_SAME;
                    end else if (nl < r_lv) begin
                        // moving down crosses nothing
                        r_l     <= nl;
                        r_state <= S_CH_LAST;
                    end else begin
                        r_state <= S_CH_WALK;
                    end
                end
                S_CH_SAME: begin
                    r_lt[r_l]          <= add63(lt_rd, r_contrib);
                    r_res.next_level   <= 3'(r_nl);
                    r_res.new_priority <= add62(r_prio, r_quanta);
                    r_state            <= S_FIN;
                end
                S_CH_WALK: begin
                    r_lt[r_l] <= add63(lt_rd, part);
                    r_contrib <= r_contrib - part;
                    r_task    <= r_task - part;
                    r_thr_cur <= thr_nx;
                    r_l       <= l_inc;
                    if (l_inc == r_nl) begin
                        r_state <= S_CH_LAST;
                    end
                end
                S_CH_LAST: begin
                    r_lt[r_l] <= add63(lt_rd, r_contrib);
                    if (!r_mp_set[r_l]) begin
                        r_mp[r_l]     <= r_total;
                        r_mp_set[r_l] <= 1'b1;
                    end
                    r_res.next_level   <= 3'(r_nl);
                    r_res.new_priority <= add62(mp_base, r_task);
                    r_state            <= S_FIN;
                end
                S_REC: begin
                    r_mp[r_l]     <= r_prio;
                    r_mp_set[r_l] <= 1'b1;
                    r_state       <= S_FIN;
                end
                S_TG_INIT: begin
                    r_best  <= lt_rd;
                    r_l     <= LW'(1);
                    r_state <= S_TG_LOAD;
                end
                S_TG_LOAD: begin
                    r_y     <= lt_rd;
                    r_k     <= '0;
                    r_state <= S_TG_UP;
                end
                S_TG_UP: begin
                    r_req   <= '{start: 1'b1, is_div: 1'b0};
                    r_opa   <= r_y;
                    r_opb   <= {{(LT_W-MULT_W){1'b0}}, eff_m};
                    r_state <= S_TG_UPW;
                end
                S_TG_UPW: begin
                    if (arith_rsp.done) begin
                        r_k <= k_inc;
                        if (k_inc == r_l) begin
                            if (up_val > r_best) begin
                                r_best <= up_val;
                            end
                            if (r_l == LAST_LVL) begin
                                r_state <= S_TG_END;
                            end else begin
                                r_l     <= l_inc;
                                r_state <= S_TG_LOAD;
                            end
                        end else begin
                            r_y     <= up_val;
                            r_state <= S_TG_UP;
                        end
                    end
                end
                S_TG_END: begin
                    r_t      <= r_best;
                    r_k      <= '0;
                    r_found  <= 1'b0;
                    r_chosen <= '0;
                    if (r_op == OP_OFFER) begin
                        r_l     <= r_lv;
                        r_state <= (r_lv == '0) ? S_OF_WR : S_OF_DIV;
                    end else begin
                        r_l     <= '0;
                        r_state <= S_SE_CHK;
                    end
                end
                S_OF_DIV: begin
                    r_req   <= '{start: 1'b1, is_div: 1'b1};
                    r_opa   <= {{(LT_W-MULT_W){1'b0}}, eff_m};
                    r_opb   <= r_t;
                    r_state <= S_OF_DIVW;
                end
                S_OF_DIVW: begin
                    if (arith_rsp.done) begin
                        r_t <= arith_acc[LT_W-1:0];
                        r_k <= k_inc;
                        r_state <= (k_inc == r_lv) ? S_OF_WR : S_OF_DIV;
                    end
                end
                S_OF_WR: begin
                    r_lt[r_l] <= r_t;
                    r_state   <= S_FIN;
                end
                S_SE_CHK: begin
                    r_y <= sel_n;
                    r_d <= sel_d;
                    if (!r_mask[r_l]) begin
                        r_state <= S_SE_ADV;
                    end else if (!r_found) begin
                        r_found  <= 1'b1;
                        r_chosen <= r_l;
                        r_bn     <= sel_n;
                        r_bd     <= sel_d;
                        r_state  <= S_SE_ADV;
                    end else begin
                        r_req   <= '{start: 1'b1, is_div: 1'b0};
                        r_opa   <= sel_n;
                        r_opb   <= r_bd;
                        r_state <= S_SE_M1W;
                    end
                end
                S_SE_M1W: begin
                    if (arith_rsp.done) begin
                        r_p1    <= arith_acc;
                        r_req   <= '{start: 1'b1, is_div: 1'b0};
                        r_opa   <= r_bn;
                        r_opb   <= r_d;
                        r_state <= S_SE_M2W;
                    end
                end
                S_SE_M2W: begin
                    if (arith_rsp.done) begin
                        // strictly greater ratio wins, ties keep the lower level
                        if (r_p1 > arith_acc) begin
                            r_chosen <= r_l;
                            r_bn     <= r_y;
                            r_bd     <= r_d;
                        end
                        r_state <= S_SE_ADV;
                    end
                end
                S_SE_ADV: begin
                    if (r_l == LAST_LVL) begin
                        r_res.chosen_level <= 3'(r_chosen);
                        r_res.level_found  <= r_found;
                        r_state            <= S_FIN;
                    end else begin
                        r_req   <= '{start: 1'b1, is_div: 1'b1};
                        r_opa   <= {{(LT_W-MULT_W){1'b0}}, eff_m};
                        r_opb   <= r_t;
                        r_state <= S_SE_DIVW;
                    end
                end
                S_SE_DIVW: begin
                    if (arith_rsp.done) begin
                        r_t     <= arith_acc[LT_W-1:0] + {{(LT_W-1){1'b0}}, rnd_up};
                        r_l     <= l_inc;
                        r_state <= S_SE_CHK;
                    end
                end
                S_FIN: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_res       = r_res;

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !arith_rsp.busy) else $error("unit busy when idle");
    a_found_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_op == OP_SELECT) |->
        (r_res.level_found == (|r_mask[NUM_LEVELS-1:0]))) else $error("found flag wrong");
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_res.next_level < 3'(NUM_LEVELS) &&
        r_res.chosen_level < 3'(NUM_LEVELS))) else $error("level out of range");

endmodule

FILE: src/multilevel_time_share_scheduler.sv
// Top level: config registers, stream ports and result register of the scheduler.
//
//  channel   dir  handshake                    contents
//  s_axis    in   s_axis_tvalid/tready         request: operation in tuser, fields in tdata
//  m_axis    out  m_axis_tvalid/tready         one result per request
//  cfg       in   i_cfg_wr_en                  register write, index and data
//
// Multiplies and divides run on the shared unit.
// Charge steps through each crossed level in turn.
// Offer: level-0 target (N*(N-1)/2 multiplies, 10 at five levels)
// plus one divide per level step. Select: target plus up to 2*(N-1) multiplies
// and N-1 divides.
// Synchronous active-low reset; accounts zero, minimum priorities unset.
// A new request is taken while a finished result waits in the output register.
module multilevel_time_share_scheduler import mlts_pkg::*; #(
    parameter int NUM_LEVELS = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [2:0] level, [64:3] task_prio, [126:65] slice_nanos,
    // [188:127] total_nanos, [193:189] waiting_mask, rest zero
    input  logic [199:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [2:0] next_level, [64:3] new_priority, [67:65] chosen_level,
    // [68] level_found, rest zero
    output logic [71:0]   m_axis_tdata,
    input  logic          i_cfg_wr_en,
    input  logic [2:0]    i_cfg_index,
    input  logic [61:0]   i_cfg_wdata
);

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;

    logic    seq_ready;
    logic    res_valid;
    t_result res;
    logic    out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr[0] <= THR0_RST;
            r_cfg.thr[1] <= THR1_RST;
            r_cfg.thr[2] <= THR2_RST;
            r_cfg.thr[3] <= THR3_RST;
            r_cfg.thr[4] <= THR4_RST;
            r_cfg.mult   <= MULT_RST;
            r_cfg.cap    <= CAP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_THR0, CFG_THR1, CFG_THR2, CFG_THR3, CFG_THR4:
                    r_cfg.thr[i_cfg_index] <= i_cfg_wdata;
                CFG_MULT: r_cfg.mult <= i_cfg_wdata[MULT_W-1:0];
                CFG_CAP:  r_cfg.cap  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;

    mlts_seq #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (s_axis_tvalid && seq_ready),
        .i_op        (t_op'(s_axis_tuser)),
        .i_level     (s_axis_tdata[2:0]),
        .i_prio      (s_axis_tdata[64:3]),
        .i_quanta    (s_axis_tdata[126:65]),
        .i_total     (s_axis_tdata[188:127]),
        .i_mask      (s_axis_tdata[193:189]),
        .o_ready     (seq_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_out_free  (out_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
            if (res_valid) begin
                r_out <= res;
            end
        end
    end

    assign s_axis_tready = seq_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out.level_found, r_out.chosen_level,
                            r_out.new_priority, r_out.next_level};

endmodule
